// ----- rtl/core/fcbm_pkg.sv -----
// Shared types, codes and constants for the block chain manager.
`timescale 1ns / 1ps
`default_nettype none

package fcbm_pkg;

   // Link entry format
   localparam int LINK_W = 16;
   localparam logic [LINK_W-1:0] LINK_FREE = 16'hFFFF;
   localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFE;

   localparam int NUM_BLOCKS_DEFAULT = 1024;

   // Request action codes
   typedef enum logic [2:0] {
      ACT_RESOLVE  = 3'd0,
      ACT_ALLOCATE = 3'd1,
      ACT_RELEASE  = 3'd2,
      ACT_READ     = 3'd3,
      ACT_WRITE    = 3'd4
   } action_type;

   // Response status codes
   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NOT_FOUND = 3'd1,
      STS_NO_SPACE  = 3'd2,
      STS_BAD_CHAIN = 3'd3,
      STS_BAD_INDEX = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [LINK_W-1:0] chain_head;
      logic [LINK_W-1:0] logical_index;
      logic [LINK_W-1:0] table_index;
      logic [LINK_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [LINK_W-1:0] block;
      logic [LINK_W-1:0] new_chain_head;
   } rsp_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_HEAD_SCAN,
      ST_WALK,
      ST_LINK_SCAN,
      ST_LINK_WRITE,
      ST_RELEASE,
      ST_READ,
      ST_DONE
   } state_type;

   // Datapath selects
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC,
      PTR_HEAD,
      PTR_TIDX,
      PTR_RDATA
   } ptr_sel_type;

   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_HEAD,
      CUR_PTR,
      CUR_RDATA
   } cur_sel_type;

   typedef enum logic [2:0] {
      WR_CLEAR,
      WR_PTR_END,
      WR_CUR_LINK,
      WR_CUR_FREE,
      WR_TIDX_VAL
   } wr_sel_type;

   typedef enum logic [1:0] {
      BLK_ZERO,
      BLK_CUR,
      BLK_RDATA
   } blk_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        capture;
      ptr_sel_type ptr_sel;
      cur_sel_type cur_sel;
      logic        step_clr;
      logic        step_inc;
      logic        seen_clr;
      logic        seen_inc;
      logic        nh_set;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        res_load;
      status_type  res_status;
      blk_sel_type res_block;
      logic        res_head_end;
      logic        rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] action;
      logic       alloc;
      logic       head_is_end;
      logic       head_valid;
      logic       tidx_valid;
      logic       rd_is_free;
      logic       rd_is_end;
      logic       rd_valid;
      logic       ptr_last;
      logic       step_done;
      logic       cur_is_end;
      logic       cur_valid;
      logic       seen_over;
      logic       rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/fat_chain_block_manager.sv -----
// Top level of the block chain manager: controller plus datapath.
//
// Keeps a NUM_BLOCKS-entry table of 16-bit next-block links (FREE, END or a
// block index) and serves one transaction at a time: resolve, resolve with
// allocate, release chain, read entry and write entry, each giving exactly
// one response. After reset a clearing pass writes FREE to every entry, one
// per cycle, with req_stall high. The table is a single-port-write memory
// read once per cycle, and that port sets the rate. A request is captured,
// then decoded. Write entry and errors found at decode (bad head, empty
// chain lookup, bad index, unused action) go from decode straight to the
// response; read entry first reads the entry, resolve walks the chain one
// link per step and release frees one block per step. Allocation adds, for
// each new block, a scan from entry 0 through the lowest free one, plus a
// write of the link when a tail is extended. The finished response is loaded
// into an output register and rsp_valid rises with it. The next request can
// be taken from the first cycle in which rsp_valid is high, so that request
// is taken while the response waits to be consumed, and a transaction only
// holds at its end while that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_block_manager #(
   parameter int NUM_BLOCKS = fcbm_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcbm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcbm_pkg::rsp_type rsp_data
);
   import fcbm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   fcbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, walk registers and response register
   fcbm_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/fcbm_datapath.sv -----
// Datapath: link table memory, walk and scan registers, response register.
`timescale 1ns / 1ps
`default_nettype none

module fcbm_datapath #(
   parameter int NUM_BLOCKS = fcbm_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  fcbm_pkg::req_type req_data,
   input  fcbm_pkg::cmd_type cmd,
   output fcbm_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fcbm_pkg::rsp_type rsp_data
);
   import fcbm_pkg::*;

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int SW = $clog2(NUM_BLOCKS + 2);
   localparam logic [LINK_W-1:0] BLOCK_LIMIT = LINK_W'(NUM_BLOCKS);
   localparam logic [AW-1:0]     LAST_ADDR   = AW'(NUM_BLOCKS - 1);
   localparam logic [SW-1:0]     SEEN_LIMIT  = SW'(NUM_BLOCKS);

   logic [LINK_W-1:0] link_mem [NUM_BLOCKS];

   req_type           req_ff;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] step_ff, step_in;
   logic [SW-1:0]     seen_ff, seen_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [LINK_W-1:0] nh_ff, nh_in;
   logic [LINK_W-1:0] rdata_ff;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]     wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic              rsp_free;

   // Table pointer: also the memory read address, so rdata_ff tracks table[ptr_ff]
   always_comb begin
      case (cmd.ptr_sel)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_ZERO:  ptr_in = '0;
         PTR_INC:   ptr_in = ptr_ff + 1'b1;
         PTR_HEAD:  ptr_in = req_ff.chain_head[AW-1:0];
         PTR_TIDX:  ptr_in = req_ff.table_index[AW-1:0];
         PTR_RDATA: ptr_in = rdata_ff[AW-1:0];
         default:   ptr_in = ptr_ff;
      endcase
   end

   // Current block of the walk
   always_comb begin
      case (cmd.cur_sel)
         CUR_HOLD:  cur_in = cur_ff;
         CUR_HEAD:  cur_in = req_ff.chain_head;
         CUR_PTR:   cur_in = LINK_W'(ptr_ff);
         CUR_RDATA: cur_in = rdata_ff;
         default:   cur_in = cur_ff;
      endcase
   end

   // Step and release counters, chain head
   always_comb begin
      step_in = step_ff;
      if (cmd.step_clr) begin
         step_in = '0;
      end else if (cmd.step_inc) begin
         step_in = step_ff + 1'b1;
      end
      seen_in = seen_ff;
      if (cmd.seen_clr) begin
         seen_in = '0;
      end else if (cmd.seen_inc) begin
         seen_in = seen_ff + 1'b1;
      end
      nh_in = nh_ff;
      if (cmd.capture) begin
         nh_in = req_data.chain_head;
      end else if (cmd.nh_set) begin
         nh_in = LINK_W'(ptr_ff);
      end
   end

   // Write port selection
   always_comb begin
      case (cmd.wr_sel)
         WR_CLEAR: begin
            wr_addr = ptr_ff;
            wr_data = LINK_FREE;
         end
         WR_PTR_END: begin
            wr_addr = ptr_ff;
            wr_data = LINK_END;
         end
         WR_CUR_LINK: begin
            wr_addr = cur_ff[AW-1:0];
            wr_data = LINK_W'(ptr_ff);
         end
         WR_CUR_FREE: begin
            wr_addr = cur_ff[AW-1:0];
            wr_data = LINK_FREE;
         end
         WR_TIDX_VAL: begin
            wr_addr = req_ff.table_index[AW-1:0];
            wr_data = req_ff.entry_value;
         end
         default: begin
            wr_addr = ptr_ff;
            wr_data = LINK_FREE;
         end
      endcase
   end

   // Link table: one write, one registered read with write-through forwarding
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (cmd.wr_en && (wr_addr == ptr_in)) begin
         rdata_ff <= wr_data;
      end else begin
         rdata_ff <= link_mem[ptr_in];
      end
   end

   // Result assembly
   always_comb begin
      res_in = res_ff;
      if (cmd.res_load) begin
         res_in.status = cmd.res_status;
         case (cmd.res_block)
            BLK_ZERO:  res_in.block = '0;
            BLK_CUR:   res_in.block = cur_ff;
            BLK_RDATA: res_in.block = rdata_ff;
            default:   res_in.block = '0;
         endcase
         res_in.new_chain_head = cmd.res_head_end ? LINK_END : nh_ff;
      end
   end

   // Output register
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
      cur_ff  <= cur_in;
      step_ff <= step_in;
      seen_ff <= seen_in;
      nh_ff   <= nh_in;
      res_ff  <= res_in;
   end

   // Status back to the controller
   always_comb begin
      sts.action      = req_ff.action;
      sts.alloc       = (req_ff.action == ACT_ALLOCATE);
      sts.head_is_end = (req_ff.chain_head == LINK_END);
      sts.head_valid  = (req_ff.chain_head < BLOCK_LIMIT);
      sts.tidx_valid  = (req_ff.table_index < BLOCK_LIMIT);
      sts.rd_is_free  = (rdata_ff == LINK_FREE);
      sts.rd_is_end   = (rdata_ff == LINK_END);
      sts.rd_valid    = (rdata_ff < BLOCK_LIMIT);
      sts.ptr_last    = (ptr_ff == LAST_ADDR);
      sts.step_done   = (step_ff == req_ff.logical_index);
      sts.cur_is_end  = (cur_ff == LINK_END);
      sts.cur_valid   = (cur_ff < BLOCK_LIMIT);
      sts.seen_over   = (seen_ff > SEEN_LIMIT);
      sts.rsp_free    = rsp_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_wr_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (32'(wr_addr) < NUM_BLOCKS))
      else $error("table write outside the data blocks");

   a_err_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STS_OK)) |-> (rsp_ff.block == '0))
      else $error("error response carries a nonzero block");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (rsp_valid_ff && (rsp_ff == $past(res_ff))))
      else $error("response register lost a loaded result");

endmodule

`default_nettype wire

// ----- rtl/core/fcbm_ctrl.sv -----
// Controller: sequences clearing, chain walks, free scans and entry access.
`timescale 1ns / 1ps
`default_nettype none

module fcbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcbm_pkg::sts_type sts,
   output fcbm_pkg::cmd_type cmd
);
   import fcbm_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.ptr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (sts.action)
               ACT_RESOLVE, ACT_ALLOCATE: begin
                  if (sts.head_is_end) begin
                     state_in = sts.alloc ? ST_HEAD_SCAN : ST_DONE;
                  end else if (!sts.head_valid) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
               ACT_RELEASE: state_in = ST_RELEASE;
               ACT_READ:    state_in = sts.tidx_valid ? ST_READ : ST_DONE;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_HEAD_SCAN: begin
            if (sts.rd_is_free) begin
               state_in = ST_WALK;
            end else if (sts.ptr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if (sts.step_done) begin
               state_in = ST_DONE;
            end else if (sts.rd_is_end) begin
               state_in = sts.alloc ? ST_LINK_SCAN : ST_DONE;
            end else if (!sts.rd_valid) begin
               state_in = ST_DONE;
            end
         end
         ST_LINK_SCAN: begin
            if (sts.rd_is_free) begin
               state_in = ST_LINK_WRITE;
            end else if (sts.ptr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_LINK_WRITE: state_in = ST_WALK;
         ST_RELEASE: begin
            if (sts.cur_is_end || !sts.cur_valid || sts.seen_over) state_in = ST_DONE;
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_CLEAR;
            cmd.ptr_sel = PTR_INC;
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            case (sts.action)
               ACT_RESOLVE, ACT_ALLOCATE: begin
                  if (sts.head_is_end) begin
                     if (sts.alloc) begin
                        cmd.ptr_sel = PTR_ZERO;
                     end else begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STS_NOT_FOUND;
                     end
                  end else if (!sts.head_valid) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STS_BAD_CHAIN;
                  end else begin
                     cmd.cur_sel  = CUR_HEAD;
                     cmd.ptr_sel  = PTR_HEAD;
                     cmd.step_clr = 1'b1;
                  end
               end
               ACT_RELEASE: begin
                  cmd.cur_sel  = CUR_HEAD;
                  cmd.ptr_sel  = PTR_HEAD;
                  cmd.seen_clr = 1'b1;
               end
               ACT_READ: begin
                  if (sts.tidx_valid) begin
                     cmd.ptr_sel = PTR_TIDX;
                  end else begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STS_BAD_INDEX;
                  end
               end
               ACT_WRITE: begin
                  cmd.res_load = 1'b1;
                  if (sts.tidx_valid) begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_sel     = WR_TIDX_VAL;
                     cmd.res_status = STS_OK;
                  end else begin
                     cmd.res_status = STS_BAD_INDEX;
                  end
               end
               default: begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STS_BAD_INDEX;
               end
            endcase
         end
         ST_HEAD_SCAN: begin
            if (sts.rd_is_free) begin
               // lowest free entry becomes the new head
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_PTR_END;
               cmd.cur_sel  = CUR_PTR;
               cmd.nh_set   = 1'b1;
               cmd.step_clr = 1'b1;
            end else if (sts.ptr_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_NO_SPACE;
            end else begin
               cmd.ptr_sel = PTR_INC;
            end
         end
         ST_WALK: begin
            if (sts.step_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_OK;
               cmd.res_block  = BLK_CUR;
            end else if (sts.rd_is_end) begin
               if (sts.alloc) begin
                  cmd.ptr_sel = PTR_ZERO;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STS_NOT_FOUND;
               end
            end else if (!sts.rd_valid) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_BAD_CHAIN;
            end else begin
               cmd.cur_sel  = CUR_RDATA;
               cmd.ptr_sel  = PTR_RDATA;
               cmd.step_inc = 1'b1;
            end
         end
         ST_LINK_SCAN: begin
            if (sts.rd_is_free) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_PTR_END;
            end else if (sts.ptr_last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_NO_SPACE;
            end else begin
               cmd.ptr_sel = PTR_INC;
            end
         end
         ST_LINK_WRITE: begin
            // hook the new block behind the old tail and step onto it
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WR_CUR_LINK;
            cmd.cur_sel  = CUR_PTR;
            cmd.step_inc = 1'b1;
         end
         ST_RELEASE: begin
            if (sts.cur_is_end) begin
               cmd.res_load     = 1'b1;
               cmd.res_status   = STS_OK;
               cmd.res_head_end = 1'b1;
            end else if (!sts.cur_valid || sts.seen_over) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_BAD_CHAIN;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = WR_CUR_FREE;
               cmd.seen_inc = 1'b1;
               cmd.cur_sel  = CUR_RDATA;
               cmd.ptr_sel  = PTR_RDATA;
            end
         end
         ST_READ: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_OK;
            cmd.res_block  = BLK_RDATA;
         end
         ST_DONE: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Checks
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded while the output register is occupied");

   a_capture_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_DECODE))
      else $error("captured transaction not decoded");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && ($past(state_ff) != ST_CLEAR)) |-> $past(reset))
      else $error("clearing pass entered without reset");

endmodule

`default_nettype wire

// ----- tb/fcbm_chain_checker.sv -----
// Checker for the block chain manager: link table predictor and response compare.
`timescale 1ns / 1ps
module fcbm_chain_checker #(
   parameter int NUM_BLOCKS = fcbm_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  fcbm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  fcbm_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                outstanding
);
   import fcbm_pkg::*;

   // Shadow copy of the link table and responses still owed by the block
   logic [LINK_W-1:0] link_shadow [NUM_BLOCKS];
   rsp_type           pending_results [$];
   rsp_type           oldest;
   int unsigned       rsp_count;

   function automatic bit is_data_block(input logic [LINK_W-1:0] b);
      return b < NUM_BLOCKS;
   endfunction

   // Lowest free entry becomes an END link; 0 when the table is full
   function automatic bit take_lowest_free(output logic [LINK_W-1:0] got);
      got = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (link_shadow[i] == LINK_FREE) begin
            link_shadow[i] = LINK_END;
            got = i[LINK_W-1:0];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Applies one transaction to the shadow table and gives the response it owes
   function automatic rsp_type chain_action_result(input req_type r);
      rsp_type           res;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] nxt;
      int unsigned       step;
      int unsigned       seen;
      bit                grow;
      res.status         = STS_OK;
      res.block          = '0;
      res.new_chain_head = r.chain_head;
      case (r.action)
         ACT_RESOLVE, ACT_ALLOCATE: begin
            grow = (r.action == ACT_ALLOCATE);
            cur  = r.chain_head;
            // empty chain: lookup misses, allocate takes a new head
            if (r.chain_head == LINK_END) begin
               if (!grow) res.status = STS_NOT_FOUND;
               else if (!take_lowest_free(cur)) res.status = STS_NO_SPACE;
               else res.new_chain_head = cur;
            end
            if (res.status == STS_OK && !is_data_block(cur)) res.status = STS_BAD_CHAIN;
            // walk, extending at END when allocating
            for (step = 0; step < r.logical_index && res.status == STS_OK; step++) begin
               nxt = link_shadow[cur];
               if (nxt == LINK_END) begin
                  if (!grow) res.status = STS_NOT_FOUND;
                  else if (!take_lowest_free(nxt)) res.status = STS_NO_SPACE;
                  else link_shadow[cur] = nxt;
               end
               if (res.status == STS_OK) begin
                  if (!is_data_block(nxt)) res.status = STS_BAD_CHAIN;
                  else cur = nxt;
               end
            end
            if (res.status == STS_OK) res.block = cur;
         end
         ACT_RELEASE: begin
            cur  = r.chain_head;
            seen = 0;
            while (cur != LINK_END && res.status == STS_OK) begin
               if (!is_data_block(cur) || seen > NUM_BLOCKS) begin
                  res.status = STS_BAD_CHAIN;
               end else begin
                  seen++;
                  nxt = link_shadow[cur];
                  link_shadow[cur] = LINK_FREE;
                  cur = nxt;
               end
            end
            if (res.status == STS_OK) res.new_chain_head = LINK_END;
         end
         ACT_READ: begin
            if (!is_data_block(r.table_index)) res.status = STS_BAD_INDEX;
            else res.block = link_shadow[r.table_index];
         end
         ACT_WRITE: begin
            if (!is_data_block(r.table_index)) res.status = STS_BAD_INDEX;
            else link_shadow[r.table_index] = r.entry_value;
         end
         default: res.status = STS_BAD_INDEX;
      endcase
      if (res.status != STS_OK) res.block = '0;
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) link_shadow[i] = LINK_FREE;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_results.size() == 0) begin
               flag_mismatch($sformatf("response %0d with no transaction pending", rsp_count));
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_data.status !== oldest.status)
                  flag_mismatch($sformatf("response %0d status %0d, want %0d",
                                          rsp_count, rsp_data.status, oldest.status));
               if (rsp_data.block !== oldest.block)
                  flag_mismatch($sformatf("response %0d block %0d, want %0d",
                                          rsp_count, rsp_data.block, oldest.block));
               if (rsp_data.new_chain_head !== oldest.new_chain_head)
                  flag_mismatch($sformatf("response %0d head %0d, want %0d", rsp_count,
                                          rsp_data.new_chain_head, oldest.new_chain_head));
            end
         end
         if (req_valid && !req_stall) pending_results.push_back(chain_action_result(req_data));
         outstanding <= pending_results.size();
      end
   end

endmodule

// ----- tb/fat_chain_block_manager_tb.sv -----
// Testbench top for the block chain manager: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fat_chain_block_manager_tb;
   import fcbm_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int NUM_BLOCKS    = NUM_BLOCKS_DEFAULT;
   localparam int FILE_SLOTS    = 8;
   localparam int RANDOM_ITEMS  = 580;
   localparam int CALM_ITEMS    = 60;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 2000000;
   localparam int NO_SLOT       = -1;
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [LINK_W-1:0] LAST_BLOCK = LINK_W'(NUM_BLOCKS - 1);
   localparam logic [LINK_W-1:0] PAST_TABLE = LINK_W'(NUM_BLOCKS);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      outstanding;
   int      quiet_cycles = 0;
   bit      idle_on = 1'b1;

   // Heads of the files the random traffic works on
   logic [LINK_W-1:0] file_head [FILE_SLOTS];
   logic [LINK_W-1:0] last_rsp_head;
   int                head_tag_q [$];

   always #HALF_PERIOD clock = ~clock;

   fat_chain_block_manager #(.NUM_BLOCKS(NUM_BLOCKS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   fcbm_chain_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Follow the file heads from allocate responses
   always @(posedge clock) begin : head_tracker
      int tag;
      if (!reset && rsp_valid && !rsp_stall) begin
         last_rsp_head = rsp_data.new_chain_head;
         if (head_tag_q.size() > 0) begin
            tag = head_tag_q.pop_front();
            if (tag != NO_SLOT) file_head[tag] = rsp_data.new_chain_head;
         end
      end
   end

   // Response stall in bursts, with longer free stretches now and then
   initial begin : rsp_stall_gen
      forever begin
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 19))
            @(negedge clock);
         if (idle_on && $urandom_range(0, 1) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type mk_req(input logic [2:0] act, input logic [LINK_W-1:0] head,
                                      input logic [LINK_W-1:0] lidx,
                                      input logic [LINK_W-1:0] tidx,
                                      input logic [LINK_W-1:0] val);
      req_type r;
      r.action        = act;
      r.chain_head    = head;
      r.logical_index = lidx;
      r.table_index   = tidx;
      r.entry_value   = val;
      return r;
   endfunction

   // One transaction, with an optional idle burst ahead of it
   task automatic issue(input req_type r, input int slot);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      head_tag_q.push_back(slot);
   endtask

   // Hold off until every owed response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [LINK_W-1:0] fill_head;
      issue(mk_req(ACT_RESOLVE, LINK_END, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, LINK_FREE, 0, 0, 0), NO_SLOT);
      // build chain 0-1-2-3, then look it up
      issue(mk_req(ACT_ALLOCATE, LINK_END, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_ALLOCATE, 0, 3, 0, 0), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, 0, 2, 0, 0), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, 0, 5, 0, 0), NO_SLOT);
      // break the chain with a FREE link: walk and release both hit it
      issue(mk_req(ACT_WRITE, 0, 0, 2, LINK_FREE), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, 0, 3, 0, 0), NO_SLOT);
      issue(mk_req(ACT_RELEASE, 0, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_READ, 0, 0, 3, 0), NO_SLOT);
      issue(mk_req(ACT_WRITE, 0, 0, 3, LINK_FREE), NO_SLOT);
      issue(mk_req(ACT_RELEASE, LINK_END, 0, 0, 0), NO_SLOT);
      // self loop walked to the deepest position
      issue(mk_req(ACT_WRITE, 0, 0, 10, 10), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, 10, 16'hFFFF, 0, 0), NO_SLOT);
      // last table entry as head, heads and links past the table
      issue(mk_req(ACT_WRITE, 0, 0, LAST_BLOCK, LINK_END), NO_SLOT);
      issue(mk_req(ACT_RESOLVE, LAST_BLOCK, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_ALLOCATE, PAST_TABLE, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_WRITE, 0, 0, 20, PAST_TABLE), NO_SLOT);
      issue(mk_req(ACT_ALLOCATE, 20, 1, 0, 0), NO_SLOT);
      issue(mk_req(ACT_READ, 7, 0, PAST_TABLE, 0), NO_SLOT);
      issue(mk_req(ACT_WRITE, 9, 0, 16'hFFFF, 16'hFFFF), NO_SLOT);
      issue(mk_req(ACT_SPARE_LO, 33, 1, 2, 3), NO_SLOT);
      issue(mk_req(ACT_SPARE_HI, LINK_END, 0, 0, 0), NO_SLOT);
      // grow one chain until the table runs out; the partial chain stays
      issue(mk_req(ACT_ALLOCATE, LINK_END, 16'hFFFF, 0, 0), NO_SLOT);
      drain_responses();
      fill_head = last_rsp_head;
      issue(mk_req(ACT_ALLOCATE, LINK_END, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_RELEASE, fill_head, 0, 0, 0), NO_SLOT);
      issue(mk_req(ACT_WRITE, 0, 0, 10, LINK_FREE), NO_SLOT);
      issue(mk_req(ACT_WRITE, 0, 0, 20, LINK_FREE), NO_SLOT);
   endtask

   // Mostly file traffic on the tracked heads, the rest raw entry access and noise
   function automatic req_type random_request(output int slot);
      req_type r;
      int      pick;
      int      which;
      r.action        = ACT_RESOLVE;
      r.chain_head    = LINK_W'($urandom);
      r.logical_index = LINK_W'($urandom);
      r.table_index   = LINK_W'($urandom);
      r.entry_value   = LINK_W'($urandom);
      which = $urandom_range(0, FILE_SLOTS - 1);
      slot  = NO_SLOT;
      pick  = $urandom_range(0, 99);
      if (pick < 35) begin
         r.action        = ACT_ALLOCATE;
         r.chain_head    = file_head[which];
         r.logical_index = ($urandom_range(0, 9) != 0) ? LINK_W'($urandom_range(0, 12))
                                                       : LINK_W'($urandom_range(13, 63));
         slot = which;
      end else if (pick < 57) begin
         r.chain_head = file_head[which];
         if ($urandom_range(0, 49) != 0) r.logical_index = LINK_W'($urandom_range(0, 16));
      end else if (pick < 67) begin
         r.action         = ACT_RELEASE;
         r.chain_head     = file_head[which];
         file_head[which] = LINK_END;
      end else if (pick < 87) begin
         r.action = (pick < 77) ? ACT_READ : ACT_WRITE;
         if ($urandom_range(0, 9) != 0)
            r.table_index = LINK_W'($urandom_range(0, NUM_BLOCKS - 1));
         case ($urandom_range(0, 3))
            0: r.entry_value = LINK_FREE;
            1: r.entry_value = LINK_END;
            2: r.entry_value = LINK_W'($urandom_range(0, NUM_BLOCKS - 1));
            default: ;
         endcase
      end else if (pick < 92) begin
         r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else begin
         r.action        = 3'($urandom_range(0, 7));
         r.logical_index = LINK_W'($urandom_range(0, 31));
      end
      return r;
   endfunction

   initial begin : stimulus
      req_type r;
      int      slot;
      for (int i = 0; i < FILE_SLOTS; i++) file_head[i] = LINK_END;
      last_rsp_head = LINK_END;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_responses();
         if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
         r = random_request(slot);
         issue(r, slot);
      end
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
